>>> rtl/itfp_pkg.sv
`default_nettype none

package itfp_pkg;

    // result kinds carried on tuser
    localparam logic KIND_VALUE = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // field identifiers
    localparam logic [3:0] FIELD_PITCH = 4'd0;
    localparam logic [3:0] FIELD_ROLL  = 4'd1;
    localparam logic [3:0] FIELD_YAW   = 4'd2;
    localparam logic [3:0] FIELD_WX    = 4'd3;
    localparam logic [3:0] FIELD_WY    = 4'd4;
    localparam logic [3:0] FIELD_WZ    = 4'd5;
    localparam logic [3:0] FIELD_AX    = 4'd6;
    localparam logic [3:0] FIELD_AY    = 4'd7;
    localparam logic [3:0] FIELD_AZ    = 4'd8;
    localparam logic [3:0] FIELD_VX    = 4'd9;
    localparam logic [3:0] FIELD_VY    = 4'd10;
    localparam logic [3:0] FIELD_VZ    = 4'd11;

    localparam int NUM_FIELDS = 12;

    // characters of interest
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // label texts, last character in the lowest byte
    localparam logic [47:0] LBL_PITCH = "Pitch:";
    localparam logic [39:0] LBL_ROLL  = "Roll:";
    localparam logic [31:0] LBL_YAW   = "Yaw:";
    localparam logic [23:0] LBL_WX    = "Wx:";
    localparam logic [23:0] LBL_WY    = "Wy:";
    localparam logic [23:0] LBL_WZ    = "Wz:";
    localparam logic [23:0] LBL_AX    = "Ax:";
    localparam logic [23:0] LBL_AY    = "Ay:";
    localparam logic [23:0] LBL_AZ    = "Az:";
    localparam logic [23:0] LBL_VX    = "Vx:";
    localparam logic [23:0] LBL_VY    = "Vy:";
    localparam logic [23:0] LBL_VZ    = "Vz:";

    // magnitude limits of a value
    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    // queue between front and back
    localparam int QDEPTH = 4;

    typedef struct packed {
        logic        hit;
        logic [3:0]  id;
    } itfp_match_t;

    // one queue entry: everything one byte causes
    typedef struct packed {
        logic        val_valid;
        logic [3:0]  field_id;
        logic [31:0] milli_value;
        logic        end_valid;
        logic [11:0] mask;
        logic        status;
    } itfp_entry_t;

    // labels end in distinct suffixes, so at most one can hit
    function automatic itfp_match_t itfp_match(input logic [47:0] win);
        itfp_match_t m;
        m.hit = 1'b1;
        m.id  = FIELD_PITCH;
        if (win == LBL_PITCH) begin
            m.id = FIELD_PITCH;
        end else if (win[39:0] == LBL_ROLL) begin
            m.id = FIELD_ROLL;
        end else if (win[31:0] == LBL_YAW) begin
            m.id = FIELD_YAW;
        end else if (win[23:0] == LBL_WX) begin
            m.id = FIELD_WX;
        end else if (win[23:0] == LBL_WY) begin
            m.id = FIELD_WY;
        end else if (win[23:0] == LBL_WZ) begin
            m.id = FIELD_WZ;
        end else if (win[23:0] == LBL_AX) begin
            m.id = FIELD_AX;
        end else if (win[23:0] == LBL_AY) begin
            m.id = FIELD_AY;
        end else if (win[23:0] == LBL_AZ) begin
            m.id = FIELD_AZ;
        end else if (win[23:0] == LBL_VX) begin
            m.id = FIELD_VX;
        end else if (win[23:0] == LBL_VY) begin
            m.id = FIELD_VY;
        end else if (win[23:0] == LBL_VZ) begin
            m.id = FIELD_VZ;
        end else begin
            m.hit = 1'b0;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/itfp_front.sv
`default_nettype none

module itfp_front #(
    parameter int FRAME_MAX    = 256,
    parameter int VALUE_WINDOW = 15
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire logic [7:0]         rx_byte,
    output logic                    push,
    output itfp_pkg::itfp_entry_t   push_data
);
    import itfp_pkg::*;

    localparam int FL_W = $clog2(FRAME_MAX + 1);
    localparam int VL_W = $clog2(VALUE_WINDOW + 1);

    logic            in_frame_reg,  in_frame_next;
    logic            prev_sp_reg,   prev_sp_next;
    logic [FL_W-1:0] flen_reg,      flen_next;
    logic [47:0]     win_reg,       win_next;
    logic            coll_reg,      coll_next;
    logic [3:0]      active_reg,    active_next;
    logic [VL_W-1:0] vlen_reg,      vlen_next;
    logic [31:0]     acc_reg,       acc_next;
    logic            neg_reg,       neg_next;
    logic            stopped_reg,   stopped_next;
    logic            begun_reg,     begun_next;
    logic [11:0]     seen_reg,      seen_next;

    logic            is_space;
    logic            is_digit;
    logic            is_ws;
    logic [FL_W-1:0] flen_inc;
    logic [VL_W-1:0] vlen_inc;
    logic [47:0]     win_shift;
    itfp_match_t     hit;
    logic [35:0]     acc_mul;
    logic [31:0]     parsed;
    logic            ends;

    assign is_space  = (rx_byte == CHAR_SPACE);
    assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign is_ws     = (rx_byte >= CHAR_TAB) && (rx_byte <= CHAR_CR);
    assign flen_inc  = flen_reg + FL_W'(1);
    assign vlen_inc  = vlen_reg + VL_W'(1);
    assign win_shift = {win_reg[39:0], rx_byte};
    assign hit       = itfp_match(win_shift);

    // times ten plus digit, 36 bits cover the capped magnitude
    assign acc_mul = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                   + {32'b0, rx_byte[3:0]};

    // signed saturation of the magnitude
    assign parsed = neg_reg ? (32'd0 - acc_reg) : (acc_reg[31] ? POS_MAX : acc_reg);

    // per-byte parser step
    always_comb begin
        in_frame_next = in_frame_reg;
        prev_sp_next  = prev_sp_reg;
        flen_next     = flen_reg;
        win_next      = win_reg;
        coll_next     = coll_reg;
        active_next   = active_reg;
        vlen_next     = vlen_reg;
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        stopped_next  = stopped_reg;
        begun_next    = begun_reg;
        seen_next     = seen_reg;
        ends          = 1'b0;

        push_data.val_valid   = 1'b0;
        push_data.field_id    = active_reg;
        push_data.milli_value = 32'd0;
        push_data.end_valid   = 1'b0;
        push_data.mask        = 12'd0;
        push_data.status      = 1'b0;

        if (accept) begin
            if (!in_frame_reg) begin
                // hunting for a frame start
                if (rx_byte == CHAR_P) begin
                    in_frame_next = 1'b1;
                    flen_next     = FL_W'(1);
                    prev_sp_next  = 1'b0;
                    win_next      = {40'd0, CHAR_P};
                    coll_next     = 1'b0;
                    seen_next     = 12'd0;
                end
            end else begin
                flen_next = flen_inc;
                if (coll_reg) begin
                    if (is_space) begin
                        push_data.val_valid   = 1'b1;
                        push_data.milli_value = parsed;
                        coll_next             = 1'b0;
                        win_next              = 48'd0;
                    end else begin
                        // digit conversion
                        if (!stopped_reg) begin
                            if (!begun_reg && is_ws) begin
                                begun_next = 1'b0;
                            end else if (!begun_reg && rx_byte == CHAR_MINUS) begin
                                begun_next = 1'b1;
                                neg_next   = 1'b1;
                            end else if (!begun_reg && rx_byte == CHAR_PLUS) begin
                                begun_next = 1'b1;
                            end else begin
                                begun_next = 1'b1;
                                if (is_digit) begin
                                    acc_next = (acc_mul > {4'b0, MAG_CAP}) ? MAG_CAP
                                                                           : acc_mul[31:0];
                                end else begin
                                    stopped_next = 1'b1;
                                end
                            end
                        end
                        vlen_next = vlen_inc;
                        if (vlen_inc >= VL_W'(VALUE_WINDOW)) begin
                            push_data.val_valid = 1'b1;
                            coll_next           = 1'b0;
                            win_next            = 48'd0;
                        end
                    end
                end else begin
                    // label search
                    win_next = win_shift;
                    if (hit.hit && !seen_reg[hit.id]) begin
                        seen_next[hit.id] = 1'b1;
                        coll_next         = 1'b1;
                        active_next       = hit.id;
                        vlen_next         = '0;
                        acc_next          = 32'd0;
                        neg_next          = 1'b0;
                        stopped_next      = 1'b0;
                        begun_next        = 1'b0;
                    end
                end

                ends         = (prev_sp_reg && is_space) || (flen_inc >= FL_W'(FRAME_MAX));
                prev_sp_next = is_space;

                // frame end, closing an open value first
                if (ends) begin
                    if (coll_next) begin
                        push_data.val_valid   = 1'b1;
                        push_data.field_id    = active_next;
                        push_data.milli_value = 32'd0;
                    end
                    push_data.end_valid = 1'b1;
                    push_data.mask      = seen_next;
                    push_data.status    = ~seen_next[FIELD_VZ];
                    in_frame_next       = 1'b0;
                    prev_sp_next        = 1'b0;
                    flen_next           = '0;
                    win_next            = 48'd0;
                    coll_next           = 1'b0;
                end
            end
        end
    end

    assign push = push_data.val_valid || push_data.end_valid;

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            prev_sp_reg  <= 1'b0;
            flen_reg     <= '0;
            win_reg      <= 48'd0;
            coll_reg     <= 1'b0;
            active_reg   <= 4'd0;
            vlen_reg     <= '0;
            acc_reg      <= 32'd0;
            neg_reg      <= 1'b0;
            stopped_reg  <= 1'b0;
            begun_reg    <= 1'b0;
            seen_reg     <= 12'd0;
        end else begin
            in_frame_reg <= in_frame_next;
            prev_sp_reg  <= prev_sp_next;
            flen_reg     <= flen_next;
            win_reg      <= win_next;
            coll_reg     <= coll_next;
            active_reg   <= active_next;
            vlen_reg     <= vlen_next;
            acc_reg      <= acc_next;
            neg_reg      <= neg_next;
            stopped_reg  <= stopped_next;
            begun_reg    <= begun_next;
            seen_reg     <= seen_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/itfp_queue.sv
`default_nettype none

module itfp_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire itfp_pkg::itfp_entry_t  push_data,
    output logic                        full,
    input  wire logic                   pop,
    output logic                        head_valid,
    output itfp_pkg::itfp_entry_t       head_data
);
    import itfp_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    itfp_entry_t     slot_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_pop;

    assign full       = (count_reg == CW'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/itfp_back.sv
`default_nettype none

module itfp_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   head_valid,
    input  wire itfp_pkg::itfp_entry_t  head_data,
    output logic                        pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [55:0]                 m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);
    import itfp_pkg::*;

    localparam logic PH_VALUE = 1'b0;
    localparam logic PH_END   = 1'b1;

    logic        phase_reg, phase_next;
    logic        valid_reg, valid_next;
    logic        kind_reg,  kind_next;
    logic [3:0]  id_reg,    id_next;
    logic [31:0] value_reg, value_next;
    logic [11:0] mask_reg,  mask_next;
    logic        stat_reg,  stat_next;
    logic        last_reg,  last_next;
    logic        load;

    assign load = head_valid && (!valid_reg || m_tready);

    // split one entry into its value and frame-end transactions
    always_comb begin
        phase_next = phase_reg;
        valid_next = valid_reg && !m_tready;
        kind_next  = kind_reg;
        id_next    = id_reg;
        value_next = value_reg;
        mask_next  = mask_reg;
        stat_next  = stat_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (head_data.val_valid && phase_reg == PH_VALUE) begin
                kind_next  = KIND_VALUE;
                id_next    = head_data.field_id;
                value_next = head_data.milli_value;
                mask_next  = 12'd0;
                stat_next  = 1'b0;
                last_next  = ~head_data.end_valid;
                if (head_data.end_valid) begin
                    phase_next = PH_END;
                end else begin
                    pop = 1'b1;
                end
            end else begin
                kind_next  = KIND_END;
                id_next    = 4'd0;
                value_next = 32'd0;
                mask_next  = head_data.mask;
                stat_next  = head_data.status;
                last_next  = 1'b1;
                phase_next = PH_VALUE;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_VALUE;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        id_reg    <= id_next;
        value_reg <= value_next;
        mask_reg  <= mask_next;
        stat_reg  <= stat_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, stat_reg, mask_reg, value_reg, id_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = kind_reg;

endmodule

`default_nettype wire

>>> rtl/imu_text_frame_parser_core.sv
`default_nettype none

// Byte-serial parser for text frames from an inertial unit. One received
// character is taken per clock whenever s_tready is high; a 'P' opens a frame,
// two spaces in a row or FRAME_MAX bytes close it. After each of the labels
// Pitch: Roll: Yaw: Wx: Wy: Wz: Ax: Ay: Az: Vx: Vy: Vz: (first occurrence per
// frame only) the text up to the next space within VALUE_WINDOW bytes is read
// as a saturated 32-bit integer in thousandths and sent out as a value
// transaction (tuser 0); every frame end sends a transaction (tuser 1) with
// the mask of labels found and a flag that is set when Vz: was missing. tlast
// marks the last transaction caused by one input byte. The parser step works
// on registered state, so input runs at one byte per clock while the queue
// is not full; results pass through a four-entry queue and an output register
// that sends one transaction per clock while m_tready is high, so a byte that
// closes both a value and the frame sends a value transaction and then a
// frame-end transaction.
module imu_text_frame_parser_core #(
    parameter int FRAME_MAX    = 256,
    parameter int VALUE_WINDOW = 15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // field_id, milli_value, updated_mask, frame_status
    output logic             m_tlast,   // last_of_run
    output logic             m_tuser    // kind
);
    import itfp_pkg::*;

    logic        accept;
    logic        push;
    logic        full;
    logic        pop;
    logic        head_valid;
    itfp_entry_t push_data;
    itfp_entry_t head_data;

    assign s_tready = ~full;
    assign accept   = s_tvalid && s_tready;

    // parser front end
    itfp_front #(
        .FRAME_MAX    (FRAME_MAX),
        .VALUE_WINDOW (VALUE_WINDOW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_byte   (s_tdata),
        .push      (push),
        .push_data (push_data)
    );

    // result queue
    itfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // output serializer
    itfp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire
